FILE: rtl/sequence_reorder_buffer_assert.svh
// ----------------------------------------------------------------------------
// Sequence reorder buffer assertion macros
// Concurrent checks on clk, disabled during rst; empty when SYNTH is set.
// ----------------------------------------------------------------------------
`ifndef SEQUENCE_REORDER_BUFFER_ASSERT_SVH
`define SEQUENCE_REORDER_BUFFER_ASSERT_SVH

`ifndef SYNTH

// property that must hold at every clock edge outside reset
`define SRB_ASSERT(label, prop) \
  label: assert property (@(posedge clk) disable iff (rst) (prop)) \
    else $error("sequence_reorder_buffer: assertion failed");

// condition that must never be seen outside reset
`define SRB_NEVER(label, cond) \
  label: assert property (@(posedge clk) disable iff (rst) !(cond)) \
    else $error("sequence_reorder_buffer: forbidden condition seen");

`else

`define SRB_ASSERT(label, prop)
`define SRB_NEVER(label, cond)

`endif

`endif

FILE: rtl/srb_pkg.sv
// ----------------------------------------------------------------------------
// srb_pkg
// Shared widths, status codes and chain types of the sequence reorder buffer.
// ----------------------------------------------------------------------------
`default_nettype none

package srb_pkg;

  localparam int SEQ_W         = 32;
  localparam int DATA_W        = 32;
  localparam int DEPTH_DEFAULT = 32;

  // result status codes
  localparam logic [1:0] ST_RELEASED = 2'd0;
  localparam logic [1:0] ST_FULL     = 2'd1;
  localparam logic [1:0] ST_STALE    = 2'd2;

  // contents of one chain entry
  typedef struct packed {
    logic              valid;
    logic [SEQ_W-1:0]  seq;
    logic [DATA_W-1:0] data;
  } entry_t;

  // command broadcast to every entry of the chain
  typedef struct packed {
    logic              insert;
    logic              pop;
    logic [SEQ_W-1:0]  key;
    logic [DATA_W-1:0] data;
  } cmd_t;

endpackage

`default_nettype wire

FILE: rtl/sequence_reorder_buffer.sv
// ----------------------------------------------------------------------------
// sequence_reorder_buffer
// Resequencer: releases items in sequence order, holds early ones in a
// sorted chain of DEPTH entries, drops stale, duplicate and overflow items.
// ----------------------------------------------------------------------------
//   channel  handshake            fields
//   input    in_valid / in_stall   seq_num, payload
//   output   out_valid / out_stall out_seq, out_payload, status, last
//
// One request is taken per cycle while no release run is in progress.
// A request in order gives one result, then, while the output is free,
// the chain drains one held item per cycle (input stalled) while its
// head continues the run. Early requests insert into the chain and give
// no result. Output is registered; a request is taken only while the
// output register is empty or being read.
// After rst: expected number 1, chain empty.
// ----------------------------------------------------------------------------
`default_nettype none

`include "sequence_reorder_buffer_assert.svh"

module sequence_reorder_buffer #(
  parameter int DEPTH = srb_pkg::DEPTH_DEFAULT
) (
  input  wire logic                        clk,
  input  wire logic                        rst,
  input  wire logic                        in_valid,
  output logic                             in_stall,
  input  wire logic [srb_pkg::SEQ_W-1:0]   seq_num,
  input  wire logic [srb_pkg::DATA_W-1:0]  payload,
  output logic                             out_valid,
  input  wire logic                        out_stall,
  output logic [srb_pkg::SEQ_W-1:0]        out_seq,
  output logic [srb_pkg::DATA_W-1:0]       out_payload,
  output logic [1:0]                       status,
  output logic                             last
);

  typedef enum logic [1:0] {
    S_IDLE  = 2'b01,
    S_DRAIN = 2'b10
  } state_t;

  state_t                      state;
  state_t                      state_next;
  logic [srb_pkg::SEQ_W-1:0]   expected_seq;
  logic [srb_pkg::SEQ_W-1:0]   expected_seq_next;
  logic [srb_pkg::SEQ_W-1:0]   expected_inc;

  srb_pkg::cmd_t               cmd;
  srb_pkg::entry_t             ent [DEPTH];
  srb_pkg::entry_t             left_ent [DEPTH];
  srb_pkg::entry_t             right_ent [DEPTH];
  logic [DEPTH-1:0]            take;
  logic [DEPTH-1:0]            left_take;
  logic [DEPTH-1:0]            match;
  logic [DEPTH-1:0]            occ;

  logic                        out_free;
  logic                        accept;
  logic                        is_next;
  logic                        is_stale;
  logic                        is_dup;
  logic                        is_full;
  logic                        run_more;
  logic                        drain_more;

  logic                        load_out;
  logic [srb_pkg::SEQ_W-1:0]   out_seq_next;
  logic [srb_pkg::DATA_W-1:0]  out_payload_next;
  logic [1:0]                  status_next;
  logic                        last_next;

  // handshake
  assign out_free = !out_valid || !out_stall;
  assign in_stall = !((state == S_IDLE) && out_free);
  assign accept   = in_valid && !in_stall;

  // classification of the arriving request
  assign expected_inc = expected_seq + {{(srb_pkg::SEQ_W-1){1'b0}}, 1'b1};
  assign is_next      = (seq_num == expected_seq);
  assign is_stale     = (seq_num < expected_seq);
  assign is_dup       = |match;
  assign is_full      = occ[DEPTH-1];
  assign run_more     = occ[0] && (ent[0].seq == expected_inc);
  assign drain_more   = occ[1] && (ent[1].seq == expected_inc);

  // chain command
  always_comb begin
    cmd.key    = seq_num;
    cmd.data   = payload;
    cmd.insert = (state == S_IDLE) && accept && !is_next && !is_stale &&
                 !is_dup && !is_full;
    cmd.pop    = (state == S_DRAIN) && out_free;
  end

  // chain of sorted entries, head at index 0
  for (genvar g = 0; g < DEPTH; g++) begin : g_chain
    if (g == 0) begin : g_head
      assign left_ent[g]  = '0;
      assign left_take[g] = 1'b0;
    end else begin : g_body
      assign left_ent[g]  = ent[g-1];
      assign left_take[g] = take[g-1];
    end
    if (g == DEPTH - 1) begin : g_tail
      assign right_ent[g] = '0;
    end else begin : g_inner
      assign right_ent[g] = ent[g+1];
    end
    assign occ[g] = ent[g].valid;

    srb_cell u_entry (
      .clk       (clk),
      .rst       (rst),
      .cmd       (cmd),
      .left_ent  (left_ent[g]),
      .left_take (left_take[g]),
      .right_ent (right_ent[g]),
      .ent       (ent[g]),
      .take      (take[g]),
      .match     (match[g])
    );
  end

  // sequencer and result selection
  always_comb begin
    state_next        = state;
    expected_seq_next = expected_seq;
    load_out          = 1'b0;
    out_seq_next      = seq_num;
    out_payload_next  = payload;
    status_next       = srb_pkg::ST_RELEASED;
    last_next         = 1'b1;
    case (state)
      S_IDLE: begin
        if (accept) begin
          if (is_next) begin
            load_out          = 1'b1;
            last_next         = !run_more;
            expected_seq_next = expected_inc;
            if (run_more) begin
              state_next = S_DRAIN;
            end
          end else if (is_stale || is_dup) begin
            load_out    = 1'b1;
            status_next = srb_pkg::ST_STALE;
          end else if (is_full) begin
            load_out    = 1'b1;
            status_next = srb_pkg::ST_FULL;
          end
        end
      end
      S_DRAIN: begin
        if (out_free) begin
          load_out          = 1'b1;
          out_seq_next      = ent[0].seq;
          out_payload_next  = ent[0].data;
          last_next         = !drain_more;
          expected_seq_next = expected_inc;
          if (!drain_more) begin
            state_next = S_IDLE;
          end
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_IDLE;
      expected_seq <= {{(srb_pkg::SEQ_W-1){1'b0}}, 1'b1};
      out_valid    <= 1'b0;
    end else begin
      state        <= state_next;
      expected_seq <= expected_seq_next;
      if (load_out) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (load_out) begin
      out_seq     <= out_seq_next;
      out_payload <= out_payload_next;
      status      <= status_next;
      last        <= last_next;
    end
  end

  // checks
  `SRB_NEVER(a_no_request_in_drain, (state == S_DRAIN) && !in_stall)
  `SRB_ASSERT(a_chain_packed, (occ & (occ + DEPTH'(1))) == '0)
  `SRB_ASSERT(a_drain_head_due, (state == S_DRAIN) |-> (occ[0] && (ent[0].seq == expected_seq)))
  `SRB_ASSERT(a_drop_ends_run, (out_valid && (status != srb_pkg::ST_RELEASED)) |-> last)

endmodule

`default_nettype wire

FILE: rtl/srb_cell.sv
// ----------------------------------------------------------------------------
// srb_cell
// One entry of the sorted chain: holds, shifts right on insert, left on pop.
// ----------------------------------------------------------------------------
`default_nettype none

module srb_cell (
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire srb_pkg::cmd_t  cmd,
  input  wire srb_pkg::entry_t left_ent,
  input  wire logic           left_take,
  input  wire srb_pkg::entry_t right_ent,
  output srb_pkg::entry_t     ent,
  output logic                take,
  output logic                match
);

  srb_pkg::entry_t ent_next;

  // the new key belongs at or before this slot
  assign take  = !ent.valid || (ent.seq > cmd.key);
  assign match = ent.valid && (ent.seq == cmd.key);

  // pop: take the right neighbour; insert: shift from the left, or take the new key at the boundary
  always_comb begin
    ent_next = ent;
    if (cmd.pop) begin
      ent_next = right_ent;
    end else if (cmd.insert && take) begin
      if (left_take) begin
        ent_next = left_ent;
      end else begin
        ent_next.valid = 1'b1;
        ent_next.seq   = cmd.key;
        ent_next.data  = cmd.data;
      end
    end
  end

  // occupancy flag cleared on reset; number and data word need no reset
  always_ff @(posedge clk) begin
    if (rst) begin
      ent.valid <= 1'b0;
    end else begin
      ent.valid <= ent_next.valid;
    end
    ent.seq  <= ent_next.seq;
    ent.data <= ent_next.data;
  end

endmodule

`default_nettype wire

FILE: test/testbench.sv
// ----------------------------------------------------------------------------
// Testbench for sequence_reorder_buffer
// Drives numbered requests in shuffled windows with stale, duplicate and
// far-future noise mixed in. A scoreboard predicts every release and drop
// and checks each result field by field. Both sides idle at random, and one
// long output hold fills the buffer.
// ----------------------------------------------------------------------------
`default_nettype none

// Predicts results from accepted requests and checks the results that come out
class reorder_scoreboard;

  typedef struct packed {
    logic [srb_pkg::SEQ_W-1:0]  seq;
    logic [srb_pkg::DATA_W-1:0] data;
    logic [1:0]                 status;
    logic                       last;
  } result_t;

  bit [srb_pkg::SEQ_W-1:0]  next_seq = 1;
  bit [srb_pkg::SEQ_W-1:0]  held_seq[$];
  bit [srb_pkg::DATA_W-1:0] held_data[$];
  result_t                  pending[$];

  int errors;
  int n_released;
  int n_full;
  int n_stale;
  int longest_run;

  // Update the predicted state for one accepted request.
  // Returns the number of results; first_status is the code of the first one.
  function int note_request(input bit [srb_pkg::SEQ_W-1:0] s,
                            input bit [srb_pkg::DATA_W-1:0] d,
                            output logic [1:0] first_status);
    int          pos;
    int          n;
    bit          dup;
    result_t     r;
    n = 0;
    dup = 1'b0;
    first_status = srb_pkg::ST_RELEASED;
    // in order: release it, then every held item that continues the run
    if (s == next_seq) begin
      r = '{s, d, srb_pkg::ST_RELEASED, 1'b0};
      pending.insert(pending.size(), r);
      n = 1;
      next_seq++;
      while (held_seq.size() > 0 && held_seq[0] == next_seq) begin
        r.seq  = held_seq[0];
        r.data = held_data[0];
        held_seq.delete(0);
        held_data.delete(0);
        pending.insert(pending.size(), r);
        n++;
        next_seq++;
      end
      pending[pending.size()-1].last = 1'b1;
      n_released += n;
      if (n > longest_run) longest_run = n;
      return n;
    end
    foreach (held_seq[i]) if (held_seq[i] == s) dup = 1'b1;
    // stale or duplicate first, then overflow
    if (s < next_seq || dup) begin
      first_status = srb_pkg::ST_STALE;
      n_stale++;
    end else if (held_seq.size() >= srb_pkg::DEPTH_DEFAULT) begin
      first_status = srb_pkg::ST_FULL;
      n_full++;
    end else begin
      // early: insert in ascending order, no result
      pos = held_seq.size();
      for (int i = held_seq.size() - 1; i >= 0; i--) if (held_seq[i] > s) pos = i;
      held_seq.insert(pos, s);
      held_data.insert(pos, d);
      return 0;
    end
    r = '{s, d, first_status, 1'b1};
    pending.insert(pending.size(), r);
    return 1;
  endfunction

  task report(string what, result_t got, result_t want);
    errors++;
    $display("MISMATCH %s: got seq %h data %h st %0d last %b, %s %h data %h st %0d last %b",
             what, got.seq, got.data, got.status, got.last, "exp seq",
             want.seq, want.data, want.status, want.last);
  endtask

  // Compare one accepted result with the oldest prediction
  task check_result(result_t got);
    result_t want;
    string   bad;
    bad = "";
    if (pending.size() == 0) begin
      report("unexpected result", got, '0);
      return;
    end
    want = pending[0];
    pending.delete(0);
    if (got.seq !== want.seq)       bad = {bad, " out_seq"};
    if (got.data !== want.data)     bad = {bad, " out_payload"};
    if (got.status !== want.status) bad = {bad, " status"};
    if (got.last !== want.last)     bad = {bad, " last"};
    if (bad != "") report(bad, got, want);
  endtask

endclass

module testbench;

  localparam int HOLD_CYCLES  = 200;
  localparam int STUCK_LIMIT  = 2000;
  localparam int RANDOM_ITEMS = 410;

  logic                       clk = 1'b0;
  logic                       rst = 1'b1;
  logic                       in_valid = 1'b0;
  logic                       in_stall;
  logic [srb_pkg::SEQ_W-1:0]  seq_num = '0;
  logic [srb_pkg::DATA_W-1:0] payload = '0;
  logic                       out_valid;
  logic                       out_stall = 1'b0;
  logic [srb_pkg::SEQ_W-1:0]  out_seq;
  logic [srb_pkg::DATA_W-1:0] out_payload;
  logic [1:0]                 status;
  logic                       last;

  reorder_scoreboard sb = new();

  bit idle_on = 1'b0;
  int hold_asks = 0;
  int sent = 0;
  int directed_sent = 0;
  int far_count = 0;

  sequence_reorder_buffer u_dut (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .seq_num     (seq_num),
    .payload     (payload),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .out_seq     (out_seq),
    .out_payload (out_payload),
    .status      (status),
    .last        (last)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // mostly no gap, some short, a few long
  function int pick_gap();
    int r;
    if (!idle_on) return 0;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  // Offer one request and wait until it is taken
  task automatic send_request(input logic [srb_pkg::SEQ_W-1:0] s,
                              input logic [srb_pkg::DATA_W-1:0] d,
                              output int n, output logic [1:0] st);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    seq_num  <= s;
    payload  <= d;
    @(posedge clk);
    while (in_stall !== 1'b0) @(posedge clk);
    n = sb.note_request(s, d, st);
    sent++;
  endtask

  task automatic send_plain(input logic [srb_pkg::SEQ_W-1:0] s,
                            input logic [srb_pkg::DATA_W-1:0] d);
    int         n;
    logic [1:0] st;
    send_request(s, d, n, st);
  endtask

  // stale, duplicate or far-future request
  task automatic send_noise();
    int                        r;
    logic [srb_pkg::SEQ_W-1:0] s;
    r = $urandom_range(0, 9);
    if (r == 0 && far_count < 3) begin
      s = 32'h8000_0000 | $urandom;
      far_count++;
    end else if (r < 5 && sb.held_seq.size() > 0) begin
      s = sb.held_seq[$urandom_range(0, sb.held_seq.size() - 1)];
    end else begin
      s = $urandom_range(0, sb.next_seq - 1);
    end
    send_plain(s, $urandom);
  endtask

  // Receiver: random stalls, plus one long hold when asked
  initial begin
    int hold_seen;
    int hold_left;
    int stall_left;
    hold_seen = 0;
    hold_left = 0;
    stall_left = 0;
    forever begin
      @(posedge clk);
      if (hold_asks != hold_seen) begin
        hold_seen = hold_asks;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        out_stall <= 1'b1;
        hold_left--;
      end else if (stall_left > 0) begin
        out_stall <= 1'b1;
        stall_left--;
      end else begin
        out_stall <= 1'b0;
        if (idle_on) begin
          if ($urandom_range(0, 99) < 25) stall_left = $urandom_range(1, 3);
          else if ($urandom_range(0, 99) < 4) stall_left = $urandom_range(15, 50);
        end
      end
    end
  end

  // Result monitor
  always @(posedge clk) begin
    if (!rst && out_valid === 1'b1 && out_stall == 1'b0)
      sb.check_result('{out_seq, out_payload, status, last});
  end

  // Watchdog: ends the run when nothing moves for too long
  initial begin
    int stuck;
    stuck = 0;
    while (stuck < STUCK_LIMIT) begin
      @(posedge clk);
      if ((in_valid && in_stall === 1'b0) || (out_valid === 1'b1 && !out_stall)) stuck = 0;
      else stuck++;
    end
    $display("watchdog: no handshake for %0d cycles, %0d results outstanding",
             STUCK_LIMIT, sb.pending.size());
    $display("RESULT: ERROR");
    $finish;
  end

  // Stimulus
  initial begin
    int                        w;
    int                        j;
    int                        n;
    int                        base_idx;
    int                        random_sent;
    bit                        first_wide;
    logic [1:0]                st;
    logic [srb_pkg::SEQ_W-1:0] tmp;
    logic [srb_pkg::SEQ_W-1:0] win[$];

    repeat (4) @(posedge clk);
    rst <= 1'b0;

    // directed: run release, stale, duplicate, extremes of both fields
    send_plain(32'd3, 32'h0000_0000);
    send_plain(32'd2, 32'hFFFF_FFFF);
    send_plain(32'd1, 32'hA5A5_A5A5);     // releases 1, 2, 3
    send_plain(32'd4, 32'h5A5A_5A5A);     // in order, single result
    send_plain(32'd0, 32'h0000_0000);     // stale at zero
    send_plain(32'd2, 32'h1234_5678);     // stale, already released
    send_plain(32'd7, 32'hDEAD_BEEF);
    send_plain(32'd7, 32'h0BAD_F00D);     // duplicate of a held number
    send_plain(32'hFFFF_FFFF, 32'hFFFF_FFFF);
    send_plain(32'h8000_0000, 32'h8000_0001);
    send_plain(32'hFFFF_FFFF, 32'h0000_0001); // duplicate at the top number
    send_plain(32'd6, 32'h0000_FFFF);
    send_plain(32'd5, 32'hFFFF_0000);     // releases 5, 6, 7
    send_plain(32'd8, 32'h7FFF_FFFF);
    directed_sent = sent;

    // random: shuffled windows starting at the next expected number
    random_sent = 0;
    first_wide = 1'b1;
    while (random_sent < RANDOM_ITEMS) begin
      idle_on = ($urandom_range(0, 3) != 0);
      w = (first_wide || $urandom_range(0, 9) == 0) ? $urandom_range(30, 40)
                                                    : $urandom_range(1, 12);
      win.delete();
      for (int i = 0; i < w; i++) win.insert(win.size(), sb.next_seq + i);
      for (int i = w - 1; i > 0; i--) begin
        j = $urandom_range(0, i);
        tmp = win[i];
        win[i] = win[j];
        win[j] = tmp;
      end
      // wide windows send their first number last so the buffer can overflow
      if (w >= 30) begin
        base_idx = 0;
        foreach (win[i]) if (win[i] == sb.next_seq) base_idx = i;
        tmp = win[base_idx];
        win[base_idx] = win[w-1];
        win[w-1] = tmp;
        if (first_wide) begin
          first_wide = 1'b0;
          hold_asks++;
        end
      end
      while (win.size() > 0) begin
        if ($urandom_range(0, 9) == 0) begin
          send_noise();
          random_sent++;
        end
        tmp = win[0];
        win.delete(0);
        send_request(tmp, $urandom, n, st);
        random_sent++;
        // an overflow drop is resent later in the window
        if (n == 1 && st == srb_pkg::ST_FULL) win.insert(win.size(), tmp);
      end
    end
    in_valid <= 1'b0;
    idle_on = 1'b0;

    while (sb.pending.size() != 0) @(posedge clk);
    repeat (3 * srb_pkg::DEPTH_DEFAULT) @(posedge clk);

    $display("Covered %0d requests (%0d directed): %0d released, %0d dropped full,",
             sent, directed_sent, sb.n_released, sb.n_full);
    $display("%0d dropped stale or duplicate; longest release run %0d results; %0d mismatches.",
             sb.n_stale, sb.longest_run, sb.errors);
    if (sb.errors == 0) $display("RESULT: OK");
    else $display("RESULT: ERROR");
    $finish;
  end

endmodule

`default_nettype wire
